// ===== src/sdi_pkg.sv =====
package sdi_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_READY_WAIT = 2'd0;
  localparam logic [1:0] REG_RESET_RETRY = 2'd1;
  localparam logic [1:0] REG_IDLE_RETRY = 2'd2;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd3;

  localparam logic [15:0] READY_WAIT_RST = 16'hFFF0;
  localparam logic [7:0] RESET_RETRY_RST = 8'd20;
  localparam logic [15:0] IDLE_RETRY_RST = 16'hFFFE;
  localparam logic [7:0] POLL_LIMIT_RST = 8'd255;

  // command steps
  localparam logic [3:0] STEP_CMD0 = 4'd0;
  localparam logic [3:0] STEP_CMD8 = 4'd1;
  localparam logic [3:0] STEP_V2_CMD55 = 4'd2;
  localparam logic [3:0] STEP_V2_ACMD41 = 4'd3;
  localparam logic [3:0] STEP_CMD58 = 4'd4;
  localparam logic [3:0] STEP_PROBE_CMD55 = 4'd5;
  localparam logic [3:0] STEP_PROBE_ACMD41 = 4'd6;
  localparam logic [3:0] STEP_V1_CMD55 = 4'd7;
  localparam logic [3:0] STEP_V1_ACMD41 = 4'd8;
  localparam logic [3:0] STEP_MMC_CMD1 = 4'd9;
  localparam logic [3:0] STEP_CMD16 = 4'd10;

  localparam logic [2:0] CARD_NONE = 3'd0;
  localparam logic [2:0] CARD_MMC = 3'd1;
  localparam logic [2:0] CARD_SDV1 = 3'd2;
  localparam logic [2:0] CARD_SDV2 = 3'd3;
  localparam logic [2:0] CARD_SDHC = 3'd4;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] R1_IDLE = 8'h01;
  localparam logic [7:0] CHECK_PATTERN = 8'hAA;
  localparam logic [7:0] NO_RESP_CODE = 8'hAA;
  localparam logic [3:0] INIT_CLOCK_BYTES = 4'd10;
  localparam logic [3:0] FRAME_BYTES = 4'd6;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       slow_clock;
    logic       done_res;
    logic [2:0] card_type;
    logic [7:0] init_code;
  } result_t;

  typedef struct packed {
    logic [15:0] ready_wait_limit;
    logic [7:0]  reset_retry_limit;
    logic [15:0] idle_exit_retry_limit;
    logic [7:0]  response_poll_limit;
  } cfg_t;

  // byte of the 6-byte command frame for a step; unknown steps fall back to CMD0
  function automatic logic [7:0] frame_byte(input logic [3:0] step, input logic [3:0] slot);
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    cmd = 6'd0;
    arg = 32'd0;
    crc = 8'h01;
    case (step)
      STEP_CMD0: begin
        crc = 8'h95;
      end
      STEP_CMD8: begin
        cmd = 6'd8;
        arg = 32'h0000_01AA;
        crc = 8'h87;
      end
      STEP_V2_CMD55, STEP_PROBE_CMD55, STEP_V1_CMD55: cmd = 6'd55;
      STEP_V2_ACMD41: begin
        cmd = 6'd41;
        arg = 32'h4000_0000;
      end
      STEP_CMD58: cmd = 6'd58;
      STEP_PROBE_ACMD41, STEP_V1_ACMD41: cmd = 6'd41;
      STEP_MMC_CMD1: cmd = 6'd1;
      STEP_CMD16: begin
        cmd = 6'd16;
        arg = 32'd512;
      end
      default: begin
        crc = 8'h95;
      end
    endcase
    case (slot)
      4'd0: b = {2'b01, cmd};
      4'd1: b = arg[31:24];
      4'd2: b = arg[23:16];
      4'd3: b = arg[15:8];
      4'd4: b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

// ===== src/sdi_in_reg.sv =====
module sdi_in_reg import sdi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== src/sdi_core.sv =====
module sdi_core import sdi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic       fire_i,
  input  item_t      item_i,
  output result_t    result_o
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_CLOCKS = 4'd1;
  localparam logic [3:0] PH_DESEL = 4'd2;
  localparam logic [3:0] PH_WAIT = 4'd3;
  localparam logic [3:0] PH_FAILDESEL = 4'd4;
  localparam logic [3:0] PH_FRAME = 4'd5;
  localparam logic [3:0] PH_POLL = 4'd6;
  localparam logic [3:0] PH_TRAILER = 4'd7;
  localparam logic [3:0] PH_FINAL = 4'd8;

  cfg_t cfg_q;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  slot_q, slot_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] retry_q, retry_d;
  logic [7:0]  tries_q, tries_d;
  logic [7:0]  last_q, last_d;
  logic [1:0]  tidx_q, tidx_d;
  logic        match_q, match_d;
  logic [2:0]  type_q, type_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_wait_limit      <= READY_WAIT_RST;
      cfg_q.reset_retry_limit     <= RESET_RETRY_RST;
      cfg_q.idle_exit_retry_limit <= IDLE_RETRY_RST;
      cfg_q.response_poll_limit   <= POLL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_READY_WAIT:  cfg_q.ready_wait_limit <= cfg_data_i;
        REG_RESET_RETRY: cfg_q.reset_retry_limit <= cfg_data_i[7:0];
        REG_IDLE_RETRY:  cfg_q.idle_exit_retry_limit <= cfg_data_i;
        REG_POLL_LIMIT:  cfg_q.response_poll_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      slot_q  <= '0;
      cmd_q   <= '0;
      wait_q  <= '0;
      retry_q <= '0;
      tries_q <= '0;
      last_q  <= IDLE_BYTE;
      tidx_q  <= '0;
      match_q <= 1'b0;
      type_q  <= CARD_NONE;
    end else if (fire_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      cmd_q   <= cmd_d;
      wait_q  <= wait_d;
      retry_q <= retry_d;
      tries_q <= tries_d;
      last_q  <= last_d;
      tidx_q  <= tidx_d;
      match_q <= match_d;
      type_q  <= type_d;
    end
  end

  always_comb begin
    logic        fin;
    logic [7:0]  resp;
    logic [15:0] wait_inc;
    logic [3:0]  ci;
    logic        special;
    phase_d  = phase_q;
    slot_d   = slot_q;
    cmd_d    = cmd_q;
    wait_d   = wait_q;
    retry_d  = retry_q;
    tries_d  = tries_q;
    last_d   = last_q;
    tidx_d   = tidx_q;
    match_d  = match_q;
    type_d   = type_q;
    fin      = 1'b0;
    resp     = IDLE_BYTE;
    wait_inc = wait_q + 16'd1;
    special  = 1'b0;
    result_o = '{tx_byte: IDLE_BYTE, chip_select_n: 1'b1, slow_clock: 1'b0,
                 done_res: 1'b0, card_type: CARD_NONE, init_code: 8'd0};

    if (!item_i.action) begin
      phase_d = PH_CLOCKS;
      slot_d  = '0;
      cmd_d   = STEP_CMD0;
      wait_d  = '0;
      retry_d = '0;
      tries_d = '0;
      last_d  = IDLE_BYTE;
      tidx_d  = '0;
      match_d = 1'b0;
      type_d  = CARD_NONE;
    end else begin
      case (phase_q)
        PH_CLOCKS: begin
          slot_d = slot_q + 4'd1;
          if (slot_q >= INIT_CLOCK_BYTES - 4'd1) begin
            slot_d  = '0;
            cmd_d   = STEP_CMD0;
            phase_d = PH_DESEL;
          end
        end
        PH_DESEL: begin
          phase_d = PH_WAIT;
          wait_d  = '0;
        end
        PH_WAIT: begin
          if (item_i.rx_byte == IDLE_BYTE) begin
            phase_d = PH_FRAME;
            slot_d  = '0;
          end else begin
            wait_d = wait_inc;
            if (wait_inc >= cfg_q.ready_wait_limit) phase_d = PH_FAILDESEL;
          end
        end
        PH_FAILDESEL: begin
          fin  = 1'b1;
          resp = IDLE_BYTE;
        end
        PH_FRAME: begin
          slot_d = slot_q + 4'd1;
          if (slot_q >= FRAME_BYTES - 4'd1) begin
            slot_d  = '0;
            phase_d = PH_POLL;
            wait_d  = '0;
          end
        end
        PH_POLL: begin
          if (item_i.rx_byte[7] && (wait_q < {8'd0, cfg_q.response_poll_limit})) begin
            wait_d = wait_inc;
          end else begin
            fin  = 1'b1;
            resp = item_i.rx_byte;
          end
        end
        PH_TRAILER: begin
          tidx_d = tidx_q + 2'd1;
          if (cmd_q == STEP_CMD8) begin
            if (tidx_q == 2'd2) match_d = (item_i.rx_byte == R1_IDLE);
            if (tidx_q == 2'd3) begin
              if (match_q && item_i.rx_byte == CHECK_PATTERN) begin
                retry_d = '0;
                cmd_d   = STEP_V2_CMD55;
                phase_d = PH_DESEL;
              end else begin
                phase_d = PH_FINAL;
              end
            end
          end else if (cmd_q == STEP_CMD58) begin
            // CCS bit of the OCR top byte
            if (tidx_q == 2'd0) match_d = item_i.rx_byte[6];
            if (tidx_q == 2'd3) begin
              type_d  = match_q ? CARD_SDHC : CARD_SDV2;
              phase_d = PH_FINAL;
            end
          end else begin
            phase_d = PH_FINAL;
          end
        end
        PH_FINAL: begin
          special  = 1'b1;
          phase_d  = PH_IDLE;
          result_o.done_res  = 1'b1;
          result_o.card_type = type_q;
          result_o.init_code = (type_q != CARD_NONE) ? 8'd0 :
                               ((last_q != 8'd0) ? last_q : NO_RESP_CODE);
        end
        default: begin
          special = 1'b1;
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (fin) begin
      case (cmd_q)
        STEP_CMD0: begin
          last_d = resp;
          if (resp == R1_IDLE) begin
            cmd_d   = STEP_CMD8;
            phase_d = PH_DESEL;
          end else if (tries_q < cfg_q.reset_retry_limit) begin
            tries_d = tries_q + 8'd1;
            cmd_d   = STEP_CMD0;
            phase_d = PH_DESEL;
          end else begin
            phase_d = PH_FINAL;
          end
        end
        STEP_CMD8: begin
          if (resp == R1_IDLE) begin
            phase_d = PH_TRAILER;
            tidx_d  = '0;
            match_d = 1'b0;
          end else begin
            cmd_d   = STEP_PROBE_CMD55;
            phase_d = PH_DESEL;
          end
        end
        STEP_CMD58: begin
          if (resp == 8'd0) begin
            phase_d = PH_TRAILER;
            tidx_d  = '0;
            match_d = 1'b0;
          end else begin
            phase_d = PH_FINAL;
          end
        end
        STEP_V2_CMD55: begin
          cmd_d   = STEP_V2_ACMD41;
          phase_d = PH_DESEL;
        end
        STEP_V2_ACMD41: begin
          last_d = resp;
          if (resp == 8'd0) begin
            cmd_d   = STEP_CMD58;
            phase_d = PH_DESEL;
          end else if (retry_q < cfg_q.idle_exit_retry_limit) begin
            retry_d = retry_q + 16'd1;
            cmd_d   = STEP_V2_CMD55;
            phase_d = PH_DESEL;
          end else begin
            phase_d = PH_FINAL;
          end
        end
        STEP_PROBE_CMD55: begin
          cmd_d   = STEP_PROBE_ACMD41;
          phase_d = PH_DESEL;
        end
        STEP_PROBE_ACMD41: begin
          last_d  = resp;
          retry_d = '0;
          phase_d = PH_DESEL;
          if (resp <= R1_IDLE) begin
            type_d = CARD_SDV1;
            cmd_d  = STEP_V1_CMD55;
          end else begin
            type_d = CARD_MMC;
            cmd_d  = STEP_MMC_CMD1;
          end
        end
        STEP_V1_CMD55: begin
          cmd_d   = STEP_V1_ACMD41;
          phase_d = PH_DESEL;
        end
        STEP_V1_ACMD41, STEP_MMC_CMD1: begin
          last_d = resp;
          if (resp == 8'd0) begin
            cmd_d   = STEP_CMD16;
            phase_d = PH_DESEL;
          end else if (retry_q < cfg_q.idle_exit_retry_limit) begin
            retry_d = retry_q + 16'd1;
            cmd_d   = (cmd_q == STEP_MMC_CMD1) ? STEP_MMC_CMD1 : STEP_V1_CMD55;
            phase_d = PH_DESEL;
          end else begin
            type_d  = CARD_NONE;
            phase_d = PH_FINAL;
          end
        end
        STEP_CMD16: begin
          if (resp != 8'd0) type_d = CARD_NONE;
          phase_d = PH_FINAL;
        end
        default: phase_d = PH_FINAL;
      endcase
    end

    // describe the next slot from the updated state
    if (!special) begin
      ci = (cmd_d > STEP_CMD16) ? STEP_CMD0 : cmd_d;
      result_o.slow_clock = 1'b1;
      if (phase_d == PH_WAIT || phase_d == PH_POLL || phase_d == PH_TRAILER ||
          phase_d == PH_FRAME) begin
        result_o.chip_select_n = 1'b0;
      end
      if (phase_d == PH_FRAME) result_o.tx_byte = frame_byte(ci, slot_d);
    end else begin
      ci = STEP_CMD0;
    end
  end

endmodule

// ===== src/sdi_out_reg.sv =====
module sdi_out_reg import sdi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== src/sd_spi_card_init_sequencer.sv =====
// SD card SPI-mode init sequencer, host side, one SPI byte slot per transaction.
// Input channel (in_valid_i/in_ready_o): action_i = 0 starts or restarts the
// sequence, action_i = 1 reports rx_byte_i, the byte the card sent in the slot
// just finished. Every input transaction yields exactly one output transaction
// describing the next slot: tx_byte_o, chip_select_n_o and slow_clock_o. When
// done_res_o is set the sequence is over and card_type_o / init_code_o hold the
// result (card type, 0 on success or the failing response byte).
// Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) are
// always accepted and must only be issued while no transaction is in flight.
// Path: an accepted input goes into the input register, then the result register.
// Throughput: one transaction per cycle while the receiver does not stall; the state
// is updated by a single pass of logic as an item moves into the result register.
// Reset brings back the default limits and an idle sequencer with both
// registers empty. If the receiver stalls, the result register holds and the
// input register still takes one more item; after that in_ready_o drops.
module sd_spi_card_init_sequencer import sdi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_n_o,
  output logic        slow_clock_o,
  output logic        done_res_o,
  output logic [2:0]  card_type_o,
  output logic [7:0]  init_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  item_t   in_item, stage_item;
  logic    stage_valid, out_free, fire;
  result_t core_result, out_result;

  assign in_item     = '{action: action_i, rx_byte: rx_byte_i};
  assign fire        = stage_valid && out_free;
  assign cfg_ready_o = 1'b1;

  sdi_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .take_i     (out_free),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  sdi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (stage_item),
    .result_o    (core_result)
  );

  sdi_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (core_result),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_result)
  );

  assign tx_byte_o       = out_result.tx_byte;
  assign chip_select_n_o = out_result.chip_select_n;
  assign slow_clock_o    = out_result.slow_clock;
  assign done_res_o      = out_result.done_res;
  assign card_type_o     = out_result.card_type;
  assign init_code_o     = out_result.init_code;

endmodule

// ===== src/sdi_checker.sv =====
module sdi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  tx_byte_o,
  input logic        chip_select_n_o,
  input logic        slow_clock_o,
  input logic        done_res_o,
  input logic [2:0]  card_type_o,
  input logic [7:0]  init_code_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // status fields are only reported on the done transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> card_type_o == 3'd0 && init_code_o == 8'd0)
    else $error("status reported outside done transaction");

  // fast-clock slots (idle or done) never select the card or drive data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slow_clock_o |-> chip_select_n_o && tx_byte_o == 8'hFF)
    else $error("card selected outside the init sequence");

  // success code only together with a known card type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> card_type_o <= 3'd4 &&
      ((card_type_o == 3'd0) == (init_code_o != 8'd0)))
    else $error("card type and init code disagree");

endmodule

bind sd_spi_card_init_sequencer sdi_checker u_sdi_checker (.*);

// ===== tb/sv/tb_sd_spi_card_init_sequencer.sv =====
`timescale 1ns / 1ps

module tb_sd_spi_card_init_sequencer;
  import sdi_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // command indexes sent in the first frame byte
  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_OP_COND = 6'd1;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;
  localparam logic [7:0] R7_VOLTAGE = 8'h01;

  // kind of card the stimulus pretends to be
  localparam logic [1:0] KIND_HC = 2'd0;
  localparam logic [1:0] KIND_V2 = 2'd1;
  localparam logic [1:0] KIND_V1 = 2'd2;
  localparam logic [1:0] KIND_MMC = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_PREAMBLE, S_DESELECT, S_READY_WAIT, S_SEL_FAIL,
    S_FRAME, S_RESP, S_TRAILER, S_FINISH
  } seq_phase_e;

  typedef struct packed {
    seq_phase_e  ph;
    logic [3:0]  slot;
    logic [3:0]  step;
    logic [15:0] wcnt;
    logic [15:0] retries;
    logic [7:0]  tries;
    logic [7:0]  last_r1;
    logic [1:0]  tidx;
    logic        tmatch;
    logic [2:0]  ctype;
    result_t     res;
  } card_seq_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        chip_select_n_o;
  logic        slow_clock_o;
  logic        done_res_o;
  logic [2:0]  card_type_o;
  logic [7:0]  init_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_READY_WAIT;
  logic [15:0] cfg_data_i = 16'h0000;

  cfg_t      lim = {READY_WAIT_RST, RESET_RETRY_RST, IDLE_RETRY_RST, POLL_LIMIT_RST};
  card_seq_t pred_seq;
  card_seq_t gen_seq;
  item_t     slot_reports_q[$];
  result_t   next_slot_q[$];
  int        gen_count = 0;
  int        acc_count = 0;
  int        res_count = 0;
  int        errors = 0;
  int        cycles = 0;
  int        hold_left = 0;
  int        gap_pct = 38;
  int        stall_pct = 48;

  // stimulus card personality
  logic [1:0] card_kind = KIND_HC;
  int         busy_left = 0;
  bit         dead_ready = 1'b0;
  bit         dead_resp = 1'b0;

  sd_spi_card_init_sequencer u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic card_seq_t seq_reset();
    card_seq_t n;
    n = '0;
    n.ph = S_IDLE;
    n.last_r1 = IDLE_BYTE;
    return n;
  endfunction

  function automatic logic [7:0] cmd_frame_byte(input logic [3:0] step, input logic [3:0] slot);
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    idx = CMD_GO_IDLE;
    arg = 32'd0;
    crc = 8'h01;
    case (step)
      STEP_CMD0: crc = 8'h95;
      STEP_CMD8: begin
        idx = CMD_SEND_IF_COND;
        arg = 32'h0000_01AA;
        crc = 8'h87;
      end
      STEP_V2_CMD55, STEP_PROBE_CMD55, STEP_V1_CMD55: idx = CMD_APP;
      STEP_V2_ACMD41: begin
        idx = CMD_SD_OP_COND;
        arg = 32'h4000_0000;
      end
      STEP_CMD58: idx = CMD_READ_OCR;
      STEP_PROBE_ACMD41, STEP_V1_ACMD41: idx = CMD_SD_OP_COND;
      STEP_MMC_CMD1: idx = CMD_OP_COND;
      STEP_CMD16: begin
        idx = CMD_SET_BLOCKLEN;
        arg = 32'd512;
      end
      default: crc = 8'h95;
    endcase
    case (slot)
      4'd0: b = {2'b01, idx};
      4'd1: b = arg[31:24];
      4'd2: b = arg[23:16];
      4'd3: b = arg[15:8];
      4'd4: b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  function automatic result_t slot_out(input card_seq_t s);
    result_t r;
    r = '0;
    r.tx_byte = IDLE_BYTE;
    r.chip_select_n = 1'b1;
    r.slow_clock = 1'b1;
    if (s.ph == S_READY_WAIT || s.ph == S_RESP || s.ph == S_TRAILER) r.chip_select_n = 1'b0;
    if (s.ph == S_FRAME) begin
      r.chip_select_n = 1'b0;
      r.tx_byte = cmd_frame_byte(s.step, s.slot);
    end
    return r;
  endfunction

  function automatic card_seq_t start_cmd(input card_seq_t s, input logic [3:0] step);
    card_seq_t n;
    n = s;
    n.step = step;
    n.ph = S_DESELECT;
    return n;
  endfunction

  // ACMD41 / CMD1 polling loop of the v1 and mmc paths
  function automatic card_seq_t op_cond_loop(input card_seq_t s, input cfg_t c,
                                             input logic [7:0] resp, input logic [3:0] again);
    card_seq_t n;
    n = s;
    n.last_r1 = resp;
    if (resp == R1_READY) begin
      n = start_cmd(n, STEP_CMD16);
    end else if (n.retries < c.idle_exit_retry_limit) begin
      n.retries = n.retries + 16'd1;
      n = start_cmd(n, again);
    end else begin
      n.ctype = CARD_NONE;
      n.ph = S_FINISH;
    end
    return n;
  endfunction

  function automatic card_seq_t finish_cmd(input card_seq_t s, input cfg_t c,
                                           input logic [7:0] resp);
    card_seq_t n;
    n = s;
    case (s.step)
      STEP_CMD0: begin
        n.last_r1 = resp;
        if (resp == R1_IDLE) begin
          n = start_cmd(n, STEP_CMD8);
        end else if (n.tries < c.reset_retry_limit) begin
          n.tries = n.tries + 8'd1;
          n = start_cmd(n, STEP_CMD0);
        end else begin
          n.ph = S_FINISH;
        end
      end
      STEP_CMD8: begin
        if (resp == R1_IDLE) begin
          n.ph = S_TRAILER;
          n.tidx = 2'd0;
          n.tmatch = 1'b0;
        end else begin
          n = start_cmd(n, STEP_PROBE_CMD55);
        end
      end
      STEP_CMD58: begin
        if (resp == R1_READY) begin
          n.ph = S_TRAILER;
          n.tidx = 2'd0;
          n.tmatch = 1'b0;
        end else begin
          n.ph = S_FINISH;
        end
      end
      STEP_V2_CMD55: n = start_cmd(n, STEP_V2_ACMD41);
      STEP_V2_ACMD41: begin
        n.last_r1 = resp;
        if (resp == R1_READY) begin
          n = start_cmd(n, STEP_CMD58);
        end else if (n.retries < c.idle_exit_retry_limit) begin
          n.retries = n.retries + 16'd1;
          n = start_cmd(n, STEP_V2_CMD55);
        end else begin
          n.ph = S_FINISH;
        end
      end
      STEP_PROBE_CMD55: n = start_cmd(n, STEP_PROBE_ACMD41);
      STEP_PROBE_ACMD41: begin
        n.last_r1 = resp;
        n.retries = 16'd0;
        if (resp <= R1_IDLE) begin
          n.ctype = CARD_SDV1;
          n = start_cmd(n, STEP_V1_CMD55);
        end else begin
          n.ctype = CARD_MMC;
          n = start_cmd(n, STEP_MMC_CMD1);
        end
      end
      STEP_V1_CMD55: n = start_cmd(n, STEP_V1_ACMD41);
      STEP_V1_ACMD41: n = op_cond_loop(n, c, resp, STEP_V1_CMD55);
      STEP_MMC_CMD1: n = op_cond_loop(n, c, resp, STEP_MMC_CMD1);
      STEP_CMD16: begin
        if (resp != R1_READY) n.ctype = CARD_NONE;
        n.ph = S_FINISH;
      end
      default: n.ph = S_FINISH;
    endcase
    return n;
  endfunction

  // four trailing bytes of R7 (CMD8) or R3 (CMD58)
  function automatic card_seq_t trailer_byte(input card_seq_t s, input logic [7:0] rx);
    card_seq_t n;
    n = s;
    n.tidx = s.tidx + 2'd1;
    if (s.step == STEP_CMD8) begin
      if (s.tidx == 2'd2) n.tmatch = (rx == R7_VOLTAGE);
      if (s.tidx == 2'd3) begin
        if (s.tmatch && rx == CHECK_PATTERN) begin
          n.retries = 16'd0;
          n = start_cmd(n, STEP_V2_CMD55);
        end else begin
          n.ph = S_FINISH;
        end
      end
    end else if (s.step == STEP_CMD58) begin
      if (s.tidx == 2'd0) n.tmatch = rx[6];
      if (s.tidx == 2'd3) begin
        n.ctype = s.tmatch ? CARD_SDHC : CARD_SDV2;
        n.ph = S_FINISH;
      end
    end else begin
      n.ph = S_FINISH;
    end
    return n;
  endfunction

  function automatic card_seq_t seq_advance(input card_seq_t s, input cfg_t c, input item_t it);
    card_seq_t n;
    n = s;
    if (!it.action) begin
      n = seq_reset();
      n.ph = S_PREAMBLE;
    end else begin
      case (s.ph)
        S_PREAMBLE: begin
          n.slot = s.slot + 4'd1;
          if (n.slot >= INIT_CLOCK_BYTES) begin
            n.slot = 4'd0;
            n = start_cmd(n, STEP_CMD0);
          end
        end
        S_DESELECT: begin
          n.ph = S_READY_WAIT;
          n.wcnt = 16'd0;
        end
        S_READY_WAIT: begin
          if (it.rx_byte == IDLE_BYTE) begin
            n.ph = S_FRAME;
            n.slot = 4'd0;
          end else begin
            n.wcnt = s.wcnt + 16'd1;
            if (n.wcnt >= c.ready_wait_limit) n.ph = S_SEL_FAIL;
          end
        end
        // card never went ready: treat the command as answered with all ones
        S_SEL_FAIL: n = finish_cmd(n, c, IDLE_BYTE);
        S_FRAME: begin
          n.slot = s.slot + 4'd1;
          if (n.slot >= FRAME_BYTES) begin
            n.slot = 4'd0;
            n.ph = S_RESP;
            n.wcnt = 16'd0;
          end
        end
        S_RESP: begin
          if (it.rx_byte[7] && s.wcnt < c.response_poll_limit) n.wcnt = s.wcnt + 16'd1;
          else n = finish_cmd(n, c, it.rx_byte);
        end
        S_TRAILER: n = trailer_byte(n, it.rx_byte);
        S_FINISH: begin
          n.ph = S_IDLE;
          n.res = '0;
          n.res.tx_byte = IDLE_BYTE;
          n.res.chip_select_n = 1'b1;
          n.res.done_res = 1'b1;
          n.res.card_type = s.ctype;
          if (s.ctype != CARD_NONE) n.res.init_code = 8'h00;
          else if (s.last_r1 != 8'h00) n.res.init_code = s.last_r1;
          else n.res.init_code = NO_RESP_CODE;
          return n;
        end
        default: begin
          // slot report with no sequence running
          n.ph = S_IDLE;
          n.res = '0;
          n.res.tx_byte = IDLE_BYTE;
          n.res.chip_select_n = 1'b1;
          return n;
        end
      endcase
    end
    n.res = slot_out(n);
    return n;
  endfunction

  // ---------------------------------------------------------------- driver / monitor

  always @(posedge clk_i) begin : drive
    item_t taken;
    item_t nxt;
    logic  load;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken.action = action_i;
        taken.rx_byte = rx_byte_i;
        pred_seq = seq_advance(pred_seq, lim, taken);
        next_slot_q.push_back(pred_seq.res);
        acc_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        load = (slot_reports_q.size() != 0) && ($urandom_range(99) >= gap_pct);
        if (load) begin
          nxt = slot_reports_q.pop_front();
          action_i <= nxt.action;
          rx_byte_i <= nxt.rx_byte;
        end
        in_valid_i <= load;
      end
    end
  end

  always @(posedge clk_i) begin : observe
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {tx_byte_o, chip_select_n_o, slow_clock_o, done_res_o, card_type_o, init_code_o};
        res_count++;
        if (next_slot_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with nothing pending", res_count);
        end else begin
          want = next_slot_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("result %0d: exp tx=%h csn=%b slow=%b done=%b type=%0d code=%h",
                       res_count, want.tx_byte, want.chip_select_n, want.slow_clock,
                       want.done_res, want.card_type, want.init_code);
              $display("           got tx=%h csn=%b slow=%b done=%b type=%0d code=%h",
                       got.tx_byte, got.chip_select_n, got.slow_clock,
                       got.done_res, got.card_type, got.init_code);
            end
          end
        end
        // long receiver back-pressure so the input side fills and stalls
        if (res_count == 500 || res_count == 1200) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic new_card();
    card_kind = 2'($urandom_range(3));
    busy_left = $urandom_range(4);
    dead_ready = (lim.ready_wait_limit <= 16'd8) && ($urandom_range(5) == 0);
    dead_resp = (lim.response_poll_limit < 8'd8) && ($urandom_range(5) == 0);
  endtask

  task automatic push_item(input logic act, input logic [7:0] rx);
    item_t it;
    it.action = act;
    it.rx_byte = rx;
    if (!act) new_card();
    gen_seq = seq_advance(gen_seq, lim, it);
    slot_reports_q.push_back(it);
    gen_count++;
  endtask

  function automatic logic [7:0] r1_reply();
    logic [7:0] r;
    int         roll;
    roll = $urandom_range(99);
    r = R1_READY;
    case (gen_seq.step)
      STEP_CMD0: begin
        if (roll < 85) r = R1_IDLE;
        else r = 8'($urandom_range(127));
      end
      STEP_CMD8: r = (card_kind <= KIND_V2 && roll < 95) ? R1_IDLE : R1_ILLEGAL;
      STEP_V2_CMD55, STEP_PROBE_CMD55, STEP_V1_CMD55: r = R1_IDLE;
      STEP_PROBE_ACMD41: r = (card_kind == KIND_MMC) ? R1_ILLEGAL : ((roll & 1) ? R1_IDLE : R1_READY);
      STEP_V2_ACMD41, STEP_V1_ACMD41, STEP_MMC_CMD1: begin
        if (busy_left > 0) begin
          busy_left--;
          r = R1_IDLE;
        end else if (roll >= 90) begin
          r = 8'($urandom_range(1, 127));
        end
      end
      default: if (roll >= 90) r = 8'($urandom_range(1, 127));
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trailer_reply();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (gen_seq.step == STEP_CMD8) begin
      if (gen_seq.tidx == 2'd2 && $urandom_range(9) != 0) b = R7_VOLTAGE;
      if (gen_seq.tidx == 2'd3 && $urandom_range(9) != 0) b = CHECK_PATTERN;
    end else if (gen_seq.tidx == 2'd0) begin
      b[6] = (card_kind == KIND_HC);
    end
    return b;
  endfunction

  task automatic make_item();
    int         roll;
    logic [7:0] b;
    roll = $urandom_range(99);
    b = 8'($urandom_range(255));
    if (gen_seq.ph == S_IDLE) begin
      push_item(roll >= 80, b);
    end else if (roll < 2) begin
      push_item(1'b0, b);
    end else if (roll < 4) begin
      push_item(1'b1, b);
    end else begin
      case (gen_seq.ph)
        S_READY_WAIT: begin
          if (dead_ready || $urandom_range(99) < 25) b = 8'($urandom_range(254));
          else b = IDLE_BYTE;
        end
        S_RESP: begin
          if (dead_resp || $urandom_range(99) < 35) b = 8'h80 | 8'($urandom_range(127));
          else b = r1_reply();
        end
        S_TRAILER: b = trailer_reply();
        default: ;
      endcase
      push_item(1'b1, b);
    end
  endtask

  task automatic run_phase(input int n_items);
    int made;
    made = 0;
    // stop at the end of a sequence where possible
    while (made < n_items || (gen_seq.ph != S_IDLE && made < n_items + 600)) begin
      made++;
      make_item();
    end
  endtask

  task automatic wait_drained();
    while (acc_count != gen_count || next_slot_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_READY_WAIT: lim.ready_wait_limit = val;
      REG_RESET_RETRY: lim.reset_retry_limit = val[7:0];
      REG_IDLE_RETRY: lim.idle_exit_retry_limit = val;
      default: lim.response_poll_limit = val[7:0];
    endcase
  endtask

  task automatic set_limits(input logic [15:0] rdy, input logic [7:0] rst_tries,
                            input logic [15:0] idle_tries, input logic [7:0] polls);
    wait_drained();
    write_reg(REG_READY_WAIT, rdy);
    write_reg(REG_RESET_RETRY, {8'h00, rst_tries});
    write_reg(REG_IDLE_RETRY, idle_tries);
    write_reg(REG_POLL_LIMIT, {8'h00, polls});
  endtask

  initial begin
    pred_seq = seq_reset();
    gen_seq = seq_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // slot reports while idle, start, restart in the preamble
    push_item(1'b1, 8'h00);
    push_item(1'b1, 8'hFF);
    push_item(1'b1, 8'hAA);
    push_item(1'b1, 8'h55);
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'h00);
    push_item(1'b1, 8'hFF);
    push_item(1'b1, 8'h5A);
    push_item(1'b0, 8'hFF);
    run_phase(180);

    set_limits(16'd1, 8'd0, 16'd0, 8'd0);
    run_phase(190);

    set_limits(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    run_phase(190);

    set_limits(16'd3, 8'd2, 16'd2, 8'd3);
    gap_pct = 48;
    stall_pct = 38;
    run_phase(190);

    set_limits(16'($urandom_range(1, 12)), 8'($urandom_range(4)),
               16'($urandom_range(5)), 8'($urandom_range(6)));
    run_phase(190);

    set_limits(16'($urandom_range(1, 12)), 8'($urandom_range(4)),
               16'($urandom_range(5)), 8'($urandom_range(6)));
    gap_pct = 0;
    stall_pct = 0;
    run_phase(190);

    set_limits(16'($urandom_range(1, 65535)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 8'($urandom_range(255)));
    run_phase(190);

    wait_drained();
    if (errors == 0 && next_slot_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
